[hw/rtl/dvrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_pkg: shared types and constants for the route table
// Item layouts, kind codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [15:0] UNREACHABLE = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DIRECT  = 2'd0,
    KIND_VECTOR  = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_LOOKUP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  neighbor_id;
    logic [7:0]  dest_id;
    logic [15:0] distance;
  } in_item_t;

  typedef struct packed {
    logic        table_changed;
    logic        entry_found;
    logic [15:0] route_distance;
    logic [7:0]  next_hop;
    logic        next_hop_valid;
  } out_item_t;

  typedef struct packed {
    logic load;        // capture input item, restart scan
    logic scan_step;   // examine one slot for matches and free space
    logic prep;        // form offered distance, rewind index
    logic clear_step;  // timeout: invalidate one slot if it is the neighbor's or routes via it
    logic commit;      // write offered route, load result register
  } dp_cmd_t;

  typedef struct packed {
    logic last;        // index at final slot
    logic nb_hit;      // neighbor entry found by scan
    logic is_timeout;  // current item is a neighbor timeout
  } dp_status_t;

endpackage

[hw/rtl/dvrt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_ctrl: sequencer for the route table
// Walks each item through scan, prepare, optional clear pass and commit,
// and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module dvrt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dvrt_pkg::dp_status_t  status,
  output dvrt_pkg::dp_cmd_t     cmd
);
  import dvrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_CLEAR,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && in_valid;
    cmd.scan_step  = (state_r == S_SCAN);
    cmd.prep       = (state_r == S_PREP);
    cmd.clear_step = (state_r == S_CLEAR);
    cmd.commit     = (state_r == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (status.last) state_r <= S_PREP;
        end
        S_PREP: begin
          state_r <= (status.is_timeout && status.nb_hit) ? S_CLEAR : S_FINISH;
        end
        S_CLEAR: begin
          if (status.last) state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  // Every commit presents a result on the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not raise out_valid");

  // No new item is taken while the table is being walked.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_CLEAR) |-> !in_ready)
    else $error("input ready during table walk");

endmodule

[hw/rtl/dvrt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrt_datapath: slot storage, scan and update logic
// Holds the table, walks one slot per cycle on command, and forms the
// result item at commit.
// ----------------------------------------------------------------------------
module dvrt_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dvrt_pkg::in_item_t    in_item,
  input  dvrt_pkg::dp_cmd_t     cmd,
  output dvrt_pkg::dp_status_t  status,
  output dvrt_pkg::out_item_t   out_item
);
  import dvrt_pkg::*;

  // table storage
  logic [TABLE_ENTRIES-1:0] slot_used_r;
  logic [7:0]               slot_dest_r [TABLE_ENTRIES];
  logic [15:0]              slot_dist_r [TABLE_ENTRIES];
  logic [7:0]               slot_hop_r  [TABLE_ENTRIES];
  logic                     slot_hv_r   [TABLE_ENTRIES];

  in_item_t   item_r;
  logic [IDX_W-1:0] idx_r;

  logic             dst_hit_r, nb_hit_r, free_hit_r;
  logic [IDX_W-1:0] dst_idx_r, nb_idx_r, free_idx_r;
  logic [15:0]      dst_dist_r, nb_dist_r;
  logic [7:0]       dst_hop_r, nb_hop_r;
  logic             dst_hv_r, nb_hv_r;

  logic [15:0] offer_dist_r;
  logic        offer_ok_r;
  logic        clr_chg_r;
  out_item_t   out_r;

  // current slot
  logic        rd_used, rd_hv;
  logic [7:0]  rd_dest, rd_hop;
  logic [15:0] rd_dist;
  logic        clr_hit;
  logic [16:0] sum;
  logic        upd, ins;
  logic [IDX_W-1:0] wr_idx;
  out_item_t   res;

  assign rd_used = slot_used_r[idx_r];
  assign rd_dest = slot_dest_r[idx_r];
  assign rd_dist = slot_dist_r[idx_r];
  assign rd_hop  = slot_hop_r[idx_r];
  assign rd_hv   = slot_hv_r[idx_r];

  assign clr_hit = rd_used &&
                   ((rd_hv && (rd_hop == item_r.neighbor_id)) || (idx_r == nb_idx_r));

  assign sum = {1'b0, item_r.distance} + {1'b0, nb_dist_r};

  assign upd    = offer_ok_r && dst_hit_r && (dst_dist_r > offer_dist_r);
  assign ins    = offer_ok_r && !dst_hit_r && free_hit_r;
  assign wr_idx = upd ? dst_idx_r : free_idx_r;

  assign status.last       = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign status.nb_hit     = nb_hit_r;
  assign status.is_timeout = (item_r.kind == KIND_TIMEOUT);

  always_comb begin
    res = '0;
    if (item_r.kind == KIND_TIMEOUT) begin
      res.table_changed  = clr_chg_r;
      res.entry_found    = nb_hit_r;
      res.route_distance = UNREACHABLE;
      res.next_hop_valid = nb_hit_r && nb_hv_r;
      res.next_hop       = (nb_hit_r && nb_hv_r) ? nb_hop_r : 8'd0;
    end else if (upd || ins) begin
      res.table_changed  = 1'b1;
      res.entry_found    = 1'b1;
      res.route_distance = offer_dist_r;
      res.next_hop       = item_r.neighbor_id;
      res.next_hop_valid = 1'b1;
    end else begin
      res.entry_found    = dst_hit_r;
      res.route_distance = dst_hit_r ? dst_dist_r : UNREACHABLE;
      res.next_hop_valid = dst_hit_r && dst_hv_r;
      res.next_hop       = (dst_hit_r && dst_hv_r) ? dst_hop_r : 8'd0;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_item;
      idx_r      <= '0;
      dst_hit_r  <= 1'b0;
      nb_hit_r   <= 1'b0;
      free_hit_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (rd_used && (rd_dest == item_r.dest_id) && !dst_hit_r) begin
        dst_hit_r  <= 1'b1;
        dst_idx_r  <= idx_r;
        dst_dist_r <= rd_dist;
        dst_hop_r  <= rd_hop;
        dst_hv_r   <= rd_hv;
      end
      if (rd_used && (rd_dest == item_r.neighbor_id) && !nb_hit_r) begin
        nb_hit_r  <= 1'b1;
        nb_idx_r  <= idx_r;
        nb_dist_r <= rd_dist;
        nb_hop_r  <= rd_hop;
        nb_hv_r   <= rd_hv;
      end
      if (!rd_used && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= idx_r;
      end
    end
    if (cmd.prep) begin
      idx_r     <= '0;
      clr_chg_r <= 1'b0;
      if (item_r.kind == KIND_DIRECT) begin
        offer_dist_r <= item_r.distance;
      end else begin
        offer_dist_r <= sum[16] ? UNREACHABLE : sum[15:0];
      end
      offer_ok_r <= (item_r.kind == KIND_DIRECT) ||
                    ((item_r.kind == KIND_VECTOR) && nb_hit_r &&
                     (nb_dist_r != UNREACHABLE) && (item_r.distance != UNREACHABLE));
    end
    if (cmd.clear_step) begin
      idx_r <= idx_r + 1'b1;
      if (clr_hit && ((rd_dist != UNREACHABLE) || rd_hv)) clr_chg_r <= 1'b1;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  // slot payload writes
  always_ff @(posedge clk) begin
    if (cmd.clear_step && clr_hit) begin
      slot_dist_r[idx_r] <= UNREACHABLE;
      slot_hv_r[idx_r]   <= 1'b0;
    end
    if (cmd.commit && (upd || ins)) begin
      slot_dest_r[wr_idx] <= item_r.dest_id;
      slot_dist_r[wr_idx] <= offer_dist_r;
      slot_hop_r[wr_idx]  <= item_r.neighbor_id;
      slot_hv_r[wr_idx]   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else if (cmd.commit && ins) begin
      slot_used_r[free_idx_r] <= 1'b1;
    end
  end

  assign out_item = out_r;

  // A timeout result never reports a reachable distance.
  a_timeout_unreach: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (item_r.kind == KIND_TIMEOUT)) |=> (out_r.route_distance == UNREACHABLE))
    else $error("timeout result with reachable distance");

  // A change always leaves an entry behind.
  a_change_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (!out_r.table_changed || out_r.entry_found))
    else $error("table changed without entry");

  // An invalid hop is always reported as zero.
  a_hop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_r.next_hop_valid || (out_r.next_hop == 8'd0)))
    else $error("invalid next hop not zero");

endmodule

[hw/rtl/distance_vector_route_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table_top: distance-vector routing table
// Fixed table of destination / distance / next-hop entries, updated by
// direct routes, relaxed vector elements and neighbor timeouts.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in_      | input     | in_valid / in_ready  | in_item  (in_item_t)
//  out_     | output    | out_valid / out_ready| out_item (out_item_t)
//
//  Walk: the table is walked one slot per cycle over the single table read
//    port; a neighbor timeout that finds its neighbor walks it a second
//    time to clear routes.
//  Reset: rst_n low clears the slot used bits, the sequencer and out_valid.
//  Stalls: the next item is taken while a result waits in the output
//    register; a finished item holds in the commit step until that
//    register is free.
//
// Each item makes one pass over all slots that records the first entry
// for the destination, the first entry for the neighbor and the first free
// slot. A prepare step forms the offered distance (saturating add for a
// vector element). A timeout that finds its neighbor then makes a second
// pass that invalidates the neighbor's slot and every route through it. The
// commit step writes the offered route (improve in place, or insert in the
// free slot) and loads the result register.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dvrt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dvrt_pkg::out_item_t  out_item
);
  import dvrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: handshakes and step order
  dvrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // table storage, scan and result register
  dvrt_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

[tb/route_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_table_checker: result predictor and comparator for the route table
// Watches both channels. Every accepted input item is applied to a private
// copy of the table to form the expected result. Every accepted result is
// compared with the oldest expected one.
// ----------------------------------------------------------------------------
module route_table_checker
  import dvrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding
);

  localparam int N = TABLE_ENTRIES;

  bit          route_used   [N];
  logic [7:0]  route_dest   [N];
  logic [15:0] route_dist   [N];
  logic [7:0]  route_hop    [N];
  bit          route_hop_ok [N];

  out_item_t   expected_q [$];

  // first used slot for id, N if none
  function automatic int find_route(logic [7:0] id);
    for (int i = 0; i < N; i++)
      if (route_used[i] && route_dest[i] == id) return i;
    return N;
  endfunction

  // improve in place on a strictly smaller distance; with no entry, take first free slot
  function automatic bit offer_route(logic [7:0] id, logic [15:0] offer_dist,
                                     logic [7:0] hop);
    int p;
    p = find_route(id);
    if (p < N) begin
      if (route_dist[p] > offer_dist) begin
        route_dist[p]   = offer_dist;
        route_hop[p]    = hop;
        route_hop_ok[p] = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    for (int i = 0; i < N; i++) begin
      if (!route_used[i]) begin
        route_used[i]   = 1'b1;
        route_dest[i]   = id;
        route_dist[i]   = offer_dist;
        route_hop[i]    = hop;
        route_hop_ok[i] = 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;  // table full, route dropped
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t   r;
    int          p;
    logic [16:0] sum;
    r = '0;
    r.route_distance = UNREACHABLE;
    if (it.kind == KIND_TIMEOUT) begin
      p = find_route(it.neighbor_id);
      if (p < N) begin
        r.entry_found    = 1'b1;
        r.next_hop_valid = route_hop_ok[p];
        r.next_hop       = route_hop_ok[p] ? route_hop[p] : 8'h00;
        for (int i = 0; i < N; i++) begin
          if (route_used[i] &&
              ((route_hop_ok[i] && route_hop[i] == it.neighbor_id) || i == p)) begin
            if (route_dist[i] != UNREACHABLE || route_hop_ok[i]) r.table_changed = 1'b1;
            route_dist[i]   = UNREACHABLE;
            route_hop_ok[i] = 1'b0;
          end
        end
        r.route_distance = route_dist[p];
      end
    end else begin
      if (it.kind == KIND_DIRECT) begin
        r.table_changed = offer_route(it.dest_id, it.distance, it.neighbor_id);
      end else if (it.kind == KIND_VECTOR) begin
        p = find_route(it.neighbor_id);
        if (p < N && route_dist[p] != UNREACHABLE && it.distance != UNREACHABLE) begin
          sum = {1'b0, it.distance} + {1'b0, route_dist[p]};
          if (sum > {1'b0, UNREACHABLE}) sum = {1'b0, UNREACHABLE};
          r.table_changed = offer_route(it.dest_id, sum[15:0], it.neighbor_id);
        end
      end
      p = find_route(it.dest_id);
      if (p < N) begin
        r.entry_found    = 1'b1;
        r.route_distance = route_dist[p];
        r.next_hop_valid = route_hop_ok[p];
        r.next_hop       = route_hop_ok[p] ? route_hop[p] : 8'h00;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < N; i++) route_used[i] = 1'b0;
      expected_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none expected: %p", $time, out_item);
        end else begin
          want = expected_q.pop_front();
          if (out_item.table_changed  !== want.table_changed  ||
              out_item.entry_found    !== want.entry_found    ||
              out_item.route_distance !== want.route_distance ||
              out_item.next_hop       !== want.next_hop       ||
              out_item.next_hop_valid !== want.next_hop_valid) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch chg/fnd/dist/hop/hv exp %b %b %h %h %b got %b %b %h %h %b",
                       $time, want.table_changed, want.entry_found, want.route_distance,
                       want.next_hop, want.next_hop_valid, out_item.table_changed,
                       out_item.entry_found, out_item.route_distance, out_item.next_hop,
                       out_item.next_hop_valid);
          end
        end
      end
      if (in_valid && in_ready) expected_q.push_back(apply_item(in_item));
      outstanding <= expected_q.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: route table stimulus and verdict
// Drives a directed set of route updates, vector elements, timeouts and
// lookups, then random traffic drawn mostly from a small id pool so that
// neighbors, relaxations and a full table all occur. Both channels idle at
// random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import dvrt_pkg::*;

  localparam int LIMIT        = 400000;  // watchdog, cycles
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_START   = 3000;    // receiver hold-off window
  localparam int HOLD_LEN     = 400;
  localparam int CALM_START   = 20000;   // no idling on either side here
  localparam int CALM_END     = 26000;
  localparam int DRAIN        = 2 * TABLE_ENTRIES + 16;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int cycle_count = 0;
  int fail_count;
  int outstanding;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  // first six ids act as neighbors; twenty ids overfill the sixteen slots
  logic [7:0] id_pool [20] = '{8'h11, 8'h00, 8'hFF, 8'h35, 8'h5C, 8'hA3,
                               8'h2A, 8'h47, 8'h01, 8'h80, 8'h7F, 8'hFE,
                               8'h10, 8'hC4, 8'hD9, 8'h63, 8'hE2, 8'h3B,
                               8'h96, 8'h08};

  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  distance_vector_route_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  route_table_checker route_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic bit calm();
    return cycle_count >= CALM_START && cycle_count < CALM_END;
  endfunction

  // Receiver: random back-pressure, one long hold-off so the block backs up
  // into its input while the sender keeps offering items.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && cycle_count >= HOLD_START) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm() ? 1'b1 : ($urandom_range(0, 99) >= 23);
    end
  end

  function automatic in_item_t make_item(kind_t k, logic [7:0] nb, logic [7:0] dst,
                                         logic [15:0] d);
    in_item_t it;
    it.kind        = k;
    it.neighbor_id = nb;
    it.dest_id     = dst;
    it.distance    = d;
    return it;
  endfunction

  // Mostly well-formed traffic over the id pool; the rest is fully random.
  function automatic in_item_t random_item();
    int          roll;
    int          pick;
    logic [7:0]  nb;
    logic [7:0]  dst;
    logic [15:0] d;
    kind_t       k;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    nb   = id_pool[$urandom_range(0, 5)];
    dst  = id_pool[$urandom_range(0, 19)];
    if (pick < 6)       d = 16'($urandom_range(0, 40));
    else if (pick < 8)  d = 16'($urandom_range(0, 65535));
    else if (pick == 8) d = 16'($urandom_range(65480, 65534));  // sums saturate
    else                d = UNREACHABLE;
    if (roll < 10) begin
      // (re)establish a neighbor's own route
      k   = KIND_DIRECT;
      dst = nb;
      d   = 16'($urandom_range(0, 40));
    end else if (roll < 28) begin
      k = KIND_DIRECT;
    end else if (roll < 58) begin
      k = KIND_VECTOR;
    end else if (roll < 70) begin
      k = KIND_TIMEOUT;
    end else if (roll < 88) begin
      k = KIND_LOOKUP;
    end else begin
      k   = kind_t'(2'($urandom_range(0, 3)));
      nb  = 8'($urandom_range(0, 255));
      dst = 8'($urandom_range(0, 255));
      d   = 16'($urandom_range(0, 65535));
    end
    return make_item(k, nb, dst, d);
  endfunction

  // One item per call. valid is only lowered when a gap is taken, so it is
  // never dropped and raised in the same step.
  task automatic send_item(input in_item_t it);
    if (!calm() && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm() && $urandom_range(0, 99) < 23) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    send_item(make_item(KIND_LOOKUP,  8'h00, 8'h2A, 16'h0000));  // empty table
    send_item(make_item(KIND_TIMEOUT, 8'h11, 8'h00, 16'h0000));  // unknown neighbor
    send_item(make_item(KIND_VECTOR,  8'h11, 8'h2A, 16'h0004));  // unknown neighbor
    send_item(make_item(KIND_DIRECT,  8'h11, 8'h11, 16'h0000));  // insert, zero distance
    send_item(make_item(KIND_DIRECT,  8'h00, 8'hFF, 16'hFFFF));  // insert as unreachable
    send_item(make_item(KIND_DIRECT,  8'h00, 8'h00, 16'h0003));
    send_item(make_item(KIND_DIRECT,  8'hFF, 8'h11, 16'h0000));  // equal: no change
    send_item(make_item(KIND_DIRECT,  8'h11, 8'h00, 16'h0005));  // larger: no change
    send_item(make_item(KIND_DIRECT,  8'h11, 8'h00, 16'h0001));  // smaller: new hop
    send_item(make_item(KIND_VECTOR,  8'hFF, 8'h2A, 16'h0004));  // unreachable neighbor
    send_item(make_item(KIND_VECTOR,  8'h11, 8'h2A, 16'hFFFF));  // unreachable advert
    send_item(make_item(KIND_VECTOR,  8'h11, 8'h2A, 16'h0007));  // relaxed insert
    send_item(make_item(KIND_DIRECT,  8'h35, 8'h35, 16'hFFF0));
    send_item(make_item(KIND_VECTOR,  8'h35, 8'h47, 16'hFFFE));  // sum saturates, inserted
    send_item(make_item(KIND_VECTOR,  8'h35, 8'h2A, 16'h000F));  // sum reaches unreachable, not better
    send_item(make_item(KIND_LOOKUP,  8'hFF, 8'h47, 16'hFFFF));
    send_item(make_item(KIND_TIMEOUT, 8'h11, 8'hFF, 16'h0000));  // clears routes via 0x11
    send_item(make_item(KIND_TIMEOUT, 8'h11, 8'h00, 16'h0000));  // already cleared
    send_item(make_item(KIND_LOOKUP,  8'h00, 8'h2A, 16'h0000));
    send_item(make_item(KIND_DIRECT,  8'h11, 8'h11, 16'h0002));  // neighbor comes back
    send_item(make_item(KIND_VECTOR,  8'h11, 8'h2A, 16'h0009));
    send_item(make_item(KIND_TIMEOUT, 8'h00, 8'h00, 16'h0000));  // only a route via it
    send_item(make_item(KIND_LOOKUP,  8'hFF, 8'hFF, 16'hFFFF));
    send_item(make_item(KIND_LOOKUP,  8'h00, 8'h00, 16'h0000));

    // --- random part ---
    repeat (RANDOM_ITEMS) send_item(random_item());

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

endmodule
